// ===== src/crcpf_pkg.sv =====
// Package for the CRC-32 packet framer: widths, register indexes, the job
// record handed from the accumulator to the serializer, and the CRC byte update.
// No dependencies.
package crcpf_pkg;

  localparam int PAYLOAD_LEN = 11;
  localparam int POS_W       = 4;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_START_MARKER = 2'd0;
  localparam cfg_index_t CFG_END_MARKER   = 2'd1;
  localparam cfg_index_t CFG_CRC_OFFSET   = 2'd2;

  localparam byte_t START_MARKER_RST = 8'd75;
  localparam byte_t END_MARKER_RST   = 8'd85;
  localparam byte_t CRC_OFFSET_RST   = 8'd48;

  // Everything the serializer needs to emit the words of one input word.
  typedef struct packed {
    logic        first;
    logic        last;
    byte_t       data;
    byte_t       sum;
    logic [31:0] crc;   // final value, already inverted
  } job_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc_feed(logic [31:0] crc, byte_t b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== src/crcpf_if.sv =====
// Handshake interfaces of the framer: payload input, frame output, config writes.
// Depends on crcpf_pkg.
interface byte_in_if;
  import crcpf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t payload_byte;
  modport source (output valid, output payload_byte, input ready);
  modport sink (input valid, input payload_byte, output ready);
endinterface

interface frame_out_if;
  import crcpf_pkg::*;
  logic  valid;
  logic  ready;
  byte_t frame_byte;
  logic  frame_end;
  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface cfg_if;
  import crcpf_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  byte_t      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/crcpf_accum.sv =====
// Input side of the framer: frame position, additive sum and running CRC.
// Builds one job record per accepted word. Depends on crcpf_pkg, crcpf_if.
module crcpf_accum (
  input  logic             clk,
  input  logic             rst,
  byte_in_if.sink          byte_in,
  input  crcpf_pkg::byte_t crc_offset,
  input  logic             job_ready,
  output logic             take,
  output crcpf_pkg::job_t  job
);
  import crcpf_pkg::*;

  logic [POS_W-1:0] pos;
  byte_t            sum;
  logic [31:0]      crc;

  logic [POS_W:0]   pos_inc;
  logic             last;
  byte_t            sum_next;
  logic [31:0]      crc_next;

  assign byte_in.ready = job_ready;
  assign take          = byte_in.valid && job_ready;

  assign pos_inc  = {1'b0, pos} + (POS_W+1)'(1);
  assign last     = pos_inc >= (POS_W+1)'(PAYLOAD_LEN);
  assign sum_next = sum + byte_in.payload_byte;
  assign crc_next = crc_feed(crc, byte_in.payload_byte + crc_offset);

  always_comb begin
    job.first = (pos == '0);
    job.last  = last;
    job.data  = byte_in.payload_byte;
    job.sum   = sum_next;
    job.crc   = ~crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
      crc <= CRC_INIT;
    end else if (take) begin
      if (last) begin
        pos <= '0;
        sum <= '0;
        crc <= CRC_INIT;
      end else begin
        pos <= pos_inc[POS_W-1:0];
        sum <= sum_next;
        crc <= crc_next;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pos} < (POS_W+1)'(PAYLOAD_LEN))
    else $error("frame position out of range");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    take && last |=> pos == '0 && sum == '0 && crc == CRC_INIT)
    else $error("state not cleared after last word of frame");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    take && !last |=> pos == $past(pos) + POS_W'(1))
    else $error("frame position did not advance");

endmodule

// ===== src/crcpf_serializer.sv =====
// Output side of the framer: holds one job and sends its words one per cycle
// unless stalled, via the output register. Depends on crcpf_pkg, crcpf_if.
module crcpf_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  crcpf_pkg::job_t  job_in,
  input  crcpf_pkg::byte_t start_marker,
  input  crcpf_pkg::byte_t end_marker,
  output logic             job_ready,
  frame_out_if.source      frame_out
);
  import crcpf_pkg::*;

  typedef enum logic [2:0] {
    ST_START, ST_DATA, ST_SUM, ST_CRC0, ST_CRC1, ST_CRC2, ST_CRC3, ST_END
  } step_t;

  step_t step, step_next;
  job_t  job;
  logic  job_valid;
  logic  out_valid;
  byte_t out_byte;
  logic  out_end;

  logic  load_out;
  logic  final_step;
  byte_t byte_sel;

  assign frame_out.valid      = out_valid;
  assign frame_out.frame_byte = out_byte;
  assign frame_out.frame_end  = out_end;

  assign load_out   = job_valid && (!out_valid || frame_out.ready);
  assign final_step = (step == ST_END) || (step == ST_DATA && !job.last);
  assign job_ready  = !job_valid || (load_out && final_step);

  always_comb begin
    unique case (step)
      ST_START: begin byte_sel = start_marker; step_next = ST_DATA; end
      ST_DATA:  begin byte_sel = job.data;     step_next = ST_SUM;  end
      ST_SUM:   begin byte_sel = job.sum;      step_next = ST_CRC0; end
      ST_CRC0:  begin byte_sel = job.crc[7:0];   step_next = ST_CRC1; end
      ST_CRC1:  begin byte_sel = job.crc[15:8];  step_next = ST_CRC2; end
      ST_CRC2:  begin byte_sel = job.crc[23:16]; step_next = ST_CRC3; end
      ST_CRC3:  begin byte_sel = job.crc[31:24]; step_next = ST_END;  end
      ST_END:   begin byte_sel = end_marker;   step_next = ST_START; end
      default:  begin byte_sel = job.data;     step_next = ST_START; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
      step      <= ST_START;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
        out_byte  <= byte_sel;
        out_end   <= (step == ST_END);
      end else if (frame_out.ready) begin
        out_valid <= 1'b0;
      end
      // a new job may land in the same cycle the old one sends its final word
      if (take) begin
        job       <= job_in;
        job_valid <= 1'b1;
        step      <= job_in.first ? ST_START : ST_DATA;
      end else if (load_out) begin
        if (final_step) job_valid <= 1'b0;
        else            step      <= step_next;
      end
    end
  end

  a_release_on_send: assert property (@(posedge clk) disable iff (rst)
    $fell(job_valid) |-> $past(load_out) && $past(final_step))
    else $error("job dropped without sending its final word");

  a_trailer_needs_last: assert property (@(posedge clk) disable iff (rst)
    job_valid && step != ST_START && step != ST_DATA |-> job.last)
    else $error("trailer words on a job that does not end the frame");

  a_start_needs_first: assert property (@(posedge clk) disable iff (rst)
    job_valid && step == ST_START |-> job.first)
    else $error("start marker on a job that does not open the frame");

endmodule

// ===== src/crc32_checksum_packet_framer.sv =====
// Top level of the CRC-32 packet framer: config registers, accumulator and
// serializer. Depends on crcpf_pkg, crcpf_if, crcpf_accum, crcpf_serializer.
//
//  channel    dir  payload                 word accepted when
//  byte_in    in   payload_byte[7:0]       byte_in.valid & byte_in.ready
//  frame_out  out  frame_byte[7:0], end    frame_out.valid & frame_out.ready
//  cfg        in   index[1:0], data[7:0]   cfg.valid & cfg.ready (always ready)
//
// One frame word leaves per cycle unless the output stalls; an input word is
// taken when the job register is free or sends its final word. Each yields
// its data word; the first adds the start marker, the last the checksum, CRC
// bytes and end marker. Output stalls back up into byte_in.ready.
// Reset (rst, synchronous) restores the marker and offset defaults and starts a
// new frame.
module crc32_checksum_packet_framer (
  input  logic        clk,
  input  logic        rst,
  byte_in_if.sink     byte_in,
  frame_out_if.source frame_out,
  cfg_if.sink         cfg
);
  import crcpf_pkg::*;

  byte_t start_marker;
  byte_t end_marker;
  byte_t crc_offset;

  logic  job_ready;
  logic  take;
  job_t  job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
      crc_offset   <= CRC_OFFSET_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_START_MARKER: start_marker <= cfg.data;
        CFG_END_MARKER:   end_marker   <= cfg.data;
        CFG_CRC_OFFSET:   crc_offset   <= cfg.data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  crcpf_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .crc_offset (crc_offset),
    .job_ready  (job_ready),
    .take       (take),
    .job        (job)
  );

  crcpf_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .job_in       (job),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .job_ready    (job_ready),
    .frame_out    (frame_out)
  );

endmodule

// ===== tb/tb_crc32_checksum_packet_framer.sv =====
// Testbench for crc32_checksum_packet_framer: drives payload bytes and config writes,
// predicts every frame word (markers, data, checksum, CRC-32) and checks the output.
// Depends on crcpf_pkg, crcpf_if and the framer RTL.
module tb_crc32_checksum_packet_framer;
  import crcpf_pkg::*;

  localparam int         CYCLE_LIMIT = 200_000;
  localparam cfg_index_t CFG_UNUSED  = 2'd3;   // no register behind this index

  typedef struct {
    byte_t data;
    logic  last;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  byte_in_if   bi ();
  frame_out_if fo ();
  cfg_if       cf ();

  crc32_checksum_packet_framer u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (bi),
    .frame_out (fo),
    .cfg       (cf)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // framer state as predicted
  logic [3:0]  frame_pos;
  byte_t       frame_sum;
  logic [31:0] frame_crc;
  byte_t       start_marker;
  byte_t       end_marker;
  byte_t       crc_offset;

  frame_word_t expected_words[$];

  int errors        = 0;
  int bytes_sent    = 0;
  int words_checked = 0;
  int frames_closed = 0;
  int cfg_writes    = 0;
  int cycles        = 0;

  bit tx_idle_en    = 1'b0;
  bit rx_idle_en    = 1'b0;
  int rx_hold_cycles = 0;

  function automatic logic [31:0] crc32_byte(logic [31:0] crc, byte_t b);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ b[i]}});
    end
    return c;
  endfunction

  function automatic byte_t pick_cfg_value();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_word(input byte_t data, input logic last);
    frame_word_t w;
    w.data = data;
    w.last = last;
    expected_words.push_back(w);
  endtask

  task automatic predict_frame_words(input byte_t b);
    logic [31:0] crc_out;
    if (frame_pos == 0) push_word(start_marker, 1'b0);
    push_word(b, 1'b0);
    frame_sum = frame_sum + b;
    frame_crc = crc32_byte(frame_crc, byte_t'(b + crc_offset));
    if (int'(frame_pos) + 1 >= PAYLOAD_LEN) begin
      crc_out = ~frame_crc;
      push_word(frame_sum, 1'b0);
      for (int k = 0; k < 4; k++) push_word(crc_out[8*k +: 8], 1'b0);
      push_word(end_marker, 1'b1);
      frame_pos = '0;
      frame_sum = '0;
      frame_crc = CRC_INIT;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  // leaves valid high; gaps and drains lower it
  task automatic send_payload(input byte_t b);
    bi.valid        <= 1'b1;
    bi.payload_byte <= b;
    do @(posedge clk); while (!bi.ready);
    predict_frame_words(b);
    bytes_sent++;
  endtask

  task automatic sender_gap(input int n);
    bi.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_frame_words();
    bi.valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic cfg_write(input cfg_index_t idx, input byte_t val);
    cf.valid <= 1'b1;
    cf.index <= idx;
    cf.data  <= val;
    do @(posedge clk); while (!cf.ready);
    case (idx)
      CFG_START_MARKER: start_marker = val;
      CFG_END_MARKER:   end_marker   = val;
      CFG_CRC_OFFSET:   crc_offset   = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic cfg_release();
    cf.valid <= 1'b0;
  endtask

  // writes only once the output side has gone quiet
  task automatic reconfigure_random();
    int n;
    drain_frame_words();
    n = $urandom_range(1, 3);
    repeat (n) cfg_write(cfg_index_t'($urandom_range(0, 3)), pick_cfg_value());
    cfg_release();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_frame();
    byte_t pattern[11];
    pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE, 8'h02, 8'h40, 8'h10};
    foreach (pattern[i]) send_payload(pattern[i]);
    drain_frame_words();
  endtask

  task automatic test_config_extremes();
    cfg_write(CFG_START_MARKER, 8'h00);
    cfg_write(CFG_END_MARKER, 8'hFF);
    cfg_write(CFG_CRC_OFFSET, 8'hFF);
    cfg_write(CFG_UNUSED, 8'h5A);   // must be ignored
    cfg_release();
    // all ones: checksum wraps many times
    repeat (PAYLOAD_LEN) send_payload(8'hFF);
    drain_frame_words();
    cfg_write(CFG_START_MARKER, 8'hFF);
    cfg_write(CFG_END_MARKER, 8'h00);
    cfg_write(CFG_CRC_OFFSET, 8'h00);
    cfg_release();
    send_payload(8'h00);
    send_payload(8'h3C);
    send_payload(8'hC3);
    drain_frame_words();
    // offset change in the middle of a frame, earlier CRC bytes stay
    cfg_write(CFG_CRC_OFFSET, 8'h80);
    cfg_release();
    repeat (PAYLOAD_LEN - 3) send_payload(byte_t'($urandom_range(0, 255)));
    drain_frame_words();
  endtask

  task automatic test_backpressure();
    rx_hold_cycles = 80;
    repeat (2 * PAYLOAD_LEN) send_payload(byte_t'($urandom_range(0, 255)));
    drain_frame_words();
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 29) == 0) reconfigure_random();
      send_payload(byte_t'($urandom_range(0, 255)));
      if (tx_idle_en && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 8));
    end
    drain_frame_words();
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    forever begin
      if (rx_hold_cycles > 0) begin
        fo.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        fo.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        fo.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    frame_word_t w;
    if (!rst && fo.valid && fo.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: frame_byte %02h frame_end %0b", fo.frame_byte, fo.frame_end);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (fo.frame_byte !== w.data) begin
          $error("frame_byte: expected %02h, actual %02h", w.data, fo.frame_byte);
          errors++;
        end
        if (fo.frame_end !== w.last) begin
          $error("frame_end: expected %0b, actual %0b", w.last, fo.frame_end);
          errors++;
        end
        words_checked++;
        if (w.last) frames_closed++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, expected_words.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    bi.valid        <= 1'b0;
    bi.payload_byte <= '0;
    cf.valid        <= 1'b0;
    cf.index        <= CFG_START_MARKER;
    cf.data         <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    frame_pos    = '0;
    frame_sum    = '0;
    frame_crc    = CRC_INIT;
    start_marker = START_MARKER_RST;
    end_marker   = END_MARKER_RST;
    crc_offset   = CRC_OFFSET_RST;

    test_default_frame();
    test_config_extremes();
    test_backpressure();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_traffic(270);
    // closing stretch at full rate
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    reconfigure_random();
    test_random_traffic(3 * PAYLOAD_LEN);

    drain_frame_words();
    repeat (20) @(posedge clk);
    $display("covered %0d payload bytes in %0d frames, %0d words checked, %0d config writes",
             bytes_sent, frames_closed, words_checked, cfg_writes);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
